### hdl/crc16lf_pkg.sv
// ----------------------------------------------------------------------------
// crc16lf_pkg
// Shared types, constants and the CRC-16/XMODEM byte update for the
// length-framed frame checker.
// ----------------------------------------------------------------------------
package crc16lf_pkg;

  localparam int unsigned CNT_W           = 9;
  localparam int unsigned PAYLOAD_LEN_POS = 7;
  localparam int unsigned MAX_FRAME       = 256;
  localparam int unsigned META_LEN        = 10;
  localparam int unsigned COUNT_SAT       = 511;
  localparam int unsigned LEN_SAT         = 255;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic [7:0]  used_length;
  } out_item_t;

  // byte-wise nibble form of poly 0x1021, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

### hdl/crc16_length_framed_check.sv
// A request goes through the input register, then the result register, into out_*.
// Throughput: one request per cycle; one byte is taken every cycle while the
//   result register is free or being drained.
// The input register stalls only when it holds a last byte and the result is not taken.
// Reset (rst_n low, synchronous) clears all frame state and both valid flags.
// ----------------------------------------------------------------------------
// crc16_length_framed_check
// Length-framed CRC-16/XMODEM frame checker: one received byte per request,
// one result per frame on the last byte.
// ----------------------------------------------------------------------------
module crc16_length_framed_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crc16lf_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crc16lf_pkg::out_item_t out_data
);

  // Input register stage
  logic                   stg_vld_r;
  crc16lf_pkg::in_item_t  stg_r;
  logic                   stg_adv;

  // Result register
  logic                   out_vld_r;
  crc16lf_pkg::out_item_t out_r;

  crc16lf_pkg::out_item_t frm_result;
  logic                   out_load;

  // A non-last byte only updates frame state, so it always advances.
  // A last byte needs room in the result register.
  assign stg_adv  = stg_vld_r && (!stg_r.last_byte || !out_vld_r || out_ready);
  assign out_load = stg_adv && stg_r.last_byte;

  // Take a new request whenever the stage is empty or moving on
  assign in_ready = !stg_vld_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  // Payload holds while the stage stalls
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_data;
    end
  end

  // Frame state and result formation
  crc16lf_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (stg_adv),
    .item   (stg_r),
    .result (frm_result)
  );

  // Hold the result until taken; a new one may load in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= frm_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r)
    else $error("result not presented after last byte");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_vld_r && stg_r.last_byte && out_vld_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.frame_valid) |->
      (out_r.used_length >= 8'(crc16lf_pkg::META_LEN)))
    else $error("valid frame shorter than header and CRC");

  a_valid_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.frame_valid) |-> (out_r.received_crc == out_r.computed_crc))
    else $error("valid frame with CRC mismatch");
`endif

endmodule

### hdl/crc16lf_frame.sv
// ----------------------------------------------------------------------------
// crc16lf_frame
// Per-frame state: running CRC, held bytes, byte count and length limit.
// Updates on each step (clearing on a last byte) and forms the result for a last byte.
// ----------------------------------------------------------------------------
module crc16lf_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  crc16lf_pkg::in_item_t  item,
  output crc16lf_pkg::out_item_t result
);

  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        held0_r, held0_nxt;
  logic [7:0]        held1_r, held1_nxt;
  crc16lf_pkg::cnt_t cnt_r, cnt_nxt;
  crc16lf_pkg::cnt_t limit_r, limit_nxt;
  logic              known_r, known_nxt;

  logic              used;
  crc16lf_pkg::cnt_t used_len;

  always_comb begin
    used      = !known_r || (cnt_r < limit_r);
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    limit_nxt = limit_r;
    known_nxt = known_r;
    cnt_nxt   = cnt_r;
    if (used) begin
      if (cnt_r >= crc16lf_pkg::CNT_W'(2)) begin
        crc_nxt = crc16lf_pkg::crc_byte(crc_r, held0_r);
      end
      held0_nxt = held1_r;
      held1_nxt = item.data_byte;
    end
    if (cnt_r == crc16lf_pkg::CNT_W'(crc16lf_pkg::PAYLOAD_LEN_POS)) begin
      limit_nxt = {1'b0, item.data_byte} + crc16lf_pkg::CNT_W'(crc16lf_pkg::META_LEN);
      known_nxt = 1'b1;
    end
    if (cnt_r != crc16lf_pkg::CNT_W'(crc16lf_pkg::COUNT_SAT)) begin
      cnt_nxt = cnt_r + crc16lf_pkg::CNT_W'(1);
    end

    used_len = cnt_nxt;
    if (known_nxt && (limit_nxt < used_len)) begin
      used_len = limit_nxt;
    end
    result.received_crc = {held1_nxt, held0_nxt};
    result.computed_crc = crc_nxt;
    result.used_length  = (used_len > crc16lf_pkg::CNT_W'(crc16lf_pkg::LEN_SAT)) ?
                          8'hFF : used_len[7:0];
    result.frame_valid  = (used_len >= crc16lf_pkg::CNT_W'(crc16lf_pkg::META_LEN)) &&
                          (cnt_nxt < crc16lf_pkg::CNT_W'(crc16lf_pkg::MAX_FRAME)) &&
                          ({held1_nxt, held0_nxt} == crc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      held0_r <= '0;
      held1_r <= '0;
      cnt_r   <= '0;
      limit_r <= '0;
      known_r <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        crc_r   <= '0;
        held0_r <= '0;
        held1_r <= '0;
        cnt_r   <= '0;
        limit_r <= '0;
        known_r <= 1'b0;
      end else begin
        crc_r   <= crc_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        cnt_r   <= cnt_nxt;
        limit_r <= limit_nxt;
        known_r <= known_nxt;
      end
    end
  end

endmodule
